// ===== hdl/iorf_pkg.sv =====
// Package for the interval overlap read filter.
// Holds the item structs, operation codes, command kinds and sequencer states.
// No dependencies.
package iorf_pkg;

	localparam int IORF_MAX_WINDOWS = 64;

	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_CHECK = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;
	localparam logic [1:0] OP_NONE  = 2'd3;

	typedef struct packed {
		logic [1:0]  operation;
		logic [15:0] seq_id;
		logic [30:0] start_pos;
		logic [30:0] end_pos;
		logic [15:0] read_length;
	} req_t;

	typedef struct packed {
		logic        keep;
		logic [31:0] deleted_reads;
		logic [31:0] total_reads;
		logic [47:0] deleted_bases;
		logic [47:0] total_bases;
		logic        table_overflow;
	} res_t;

	typedef enum logic [1:0] {
		KIND_LOAD,
		KIND_CHECK,
		KIND_CLEAR
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [15:0] seq_id;
		logic [30:0] start_pos;
		logic [31:0] bound;
		logic [15:0] read_length;
	} cmd_t;

	typedef struct packed {
		logic [15:0] seq_id;
		logic [30:0] begin_pos;
		logic [30:0] end_pos;
	} win_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} state_t;

endpackage

// ===== hdl/interval_overlap_read_filter.sv =====
// Interval overlap read filter, top level.
// Depends on iorf_pkg, iorf_front and iorf_back.
//
// Usage: items enter on req with push/full, results leave on res with empty/pop.
// An item with operation load stores a window [start_pos, end_pos) for seq_id,
// check tests a read [start_pos, end_pos] against all stored windows on the
// same seq_id, and clear empties the table and zeroes all counters.
// Only a check produces a result; it holds keep and the saturating counters
// including that read, plus the sticky table overflow flag.
// A two-item command queue separates the front end from the table sequencer.
// A load or clear is done in the sequencer's idle state. A check walks the
// window table one entry per cycle through a RAM with registered read, then
// passes a drain state and waits in a done state until the output register
// is free; with an empty table it goes straight to the done state.
// After reset the table is empty, all counters and the overflow flag are zero.
// When the receiver does not pop, one finished result waits in the output
// register while the queue keeps accepting items until it fills; then full
// rises and stays high until results are taken.
module interval_overlap_read_filter import iorf_pkg::*; #(
	parameter int MAX_WINDOWS = IORF_MAX_WINDOWS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  req_t req,
	output logic empty,
	input  logic pop,
	output res_t res
);

	logic cmd_valid;
	logic cmd_take;
	cmd_t cmd;

	iorf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.req       (req),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take)
	);

	iorf_back #(
		.MAX_WINDOWS (MAX_WINDOWS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take),
		.empty     (empty),
		.pop       (pop),
		.res       (res)
	);

endmodule

// ===== hdl/iorf_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module iorf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hdl/iorf_front.sv =====
// Front end: accepts items, classifies them into commands and queues them.
// Depends on iorf_pkg.
module iorf_front import iorf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  req_t req,
	output logic cmd_valid,
	output cmd_t cmd,
	input  logic cmd_take
);

	localparam logic [1:0] QUEUE_DEPTH = 2'd2;

	cmd_t       queue_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	cmd_t       cmd_in;
	logic       do_write;

	always_comb begin
		cmd_in.seq_id      = req.seq_id;
		cmd_in.start_pos   = req.start_pos;
		cmd_in.read_length = req.read_length;
		cmd_in.bound       = {1'b0, req.end_pos};
		cmd_in.kind        = KIND_LOAD;
		unique case (req.operation)
			OP_LOAD: begin
				cmd_in.kind = KIND_LOAD;
			end
			OP_CHECK: begin
				cmd_in.kind  = KIND_CHECK;
				cmd_in.bound = {1'b0, req.end_pos} + 32'd1;
			end
			OP_CLEAR: begin
				cmd_in.kind = KIND_CLEAR;
			end
			default: begin
				cmd_in.kind = KIND_LOAD;
			end
		endcase
	end

	assign full      = (fill_q == QUEUE_DEPTH);
	assign do_write  = push && !full && (req.operation != OP_NONE);
	assign cmd_valid = (fill_q != 2'd0);
	assign cmd       = queue_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (do_write) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (cmd_take) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			unique case ({do_write, cmd_take})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_write) begin
			queue_q[wr_ptr_q] <= cmd_in;
		end
	end

endmodule

// ===== hdl/iorf_back.sv =====
// Back end: window table, scan sequencer, saturating counters and result register.
// Depends on iorf_pkg and iorf_ram.
module iorf_back import iorf_pkg::*; #(
	parameter int MAX_WINDOWS = IORF_MAX_WINDOWS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	input  cmd_t cmd,
	output logic cmd_take,
	output logic empty,
	input  logic pop,
	output res_t res
);

	localparam int AW = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
	localparam int CW = $clog2(MAX_WINDOWS + 1);
	localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_WINDOWS);

	state_t         state_q;
	state_t         state_d;
	cmd_t           cmd_q;
	logic [CW-1:0]  count_q;
	logic [AW-1:0]  idx_q;
	logic           hit_q;
	logic           rd_pending_s1;
	logic           overflow_q;
	logic [31:0]    del_reads_q;
	logic [31:0]    tot_reads_q;
	logic [47:0]    del_bases_q;
	logic [47:0]    tot_bases_q;
	logic           res_valid_q;
	res_t           res_q;

	logic           slot_free;
	logic           ram_we;
	logic           ram_re;
	win_t           wr_win;
	win_t           rd_win;
	logic [30:0]    left;
	logic [31:0]    right;
	logic           match;
	logic           last_idx;
	logic [48:0]    tot_sum;
	logic [48:0]    del_sum;
	logic [47:0]    tot_bases_n;
	logic [47:0]    del_bases_n;
	logic [31:0]    tot_reads_n;
	logic [31:0]    del_reads_n;

	assign wr_win.seq_id    = cmd.seq_id;
	assign wr_win.begin_pos = cmd.start_pos;
	assign wr_win.end_pos   = cmd.bound[30:0];

	iorf_ram #(
		.WIDTH ($bits(win_t)),
		.DEPTH (MAX_WINDOWS)
	) u_win_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[AW-1:0]),
		.wdata (wr_win),
		.re    (ram_re),
		.raddr (idx_q),
		.rdata (rd_win)
	);

	assign left  = (cmd_q.start_pos > rd_win.begin_pos) ? cmd_q.start_pos : rd_win.begin_pos;
	assign right = (cmd_q.bound < {1'b0, rd_win.end_pos}) ? cmd_q.bound
		: {1'b0, rd_win.end_pos};
	assign match = (rd_win.seq_id == cmd_q.seq_id) && ({1'b0, left} < right);

	assign last_idx  = (CW'(idx_q) == count_q - CW'(1));
	assign slot_free = !res_valid_q || pop;

	assign tot_sum     = {1'b0, tot_bases_q} + 49'(cmd_q.read_length);
	assign del_sum     = {1'b0, del_bases_q} + 49'(cmd_q.read_length);
	assign tot_bases_n = tot_sum[48] ? '1 : tot_sum[47:0];
	assign del_bases_n = del_sum[48] ? '1 : del_sum[47:0];
	assign tot_reads_n = (&tot_reads_q) ? tot_reads_q : tot_reads_q + 32'd1;
	assign del_reads_n = (&del_reads_q) ? del_reads_q : del_reads_q + 32'd1;

	always_comb begin
		state_d  = state_q;
		cmd_take = 1'b0;
		ram_we   = 1'b0;
		ram_re   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					cmd_take = 1'b1;
					if (cmd.kind == KIND_LOAD) begin
						ram_we = (count_q < FULL_COUNT);
					end else if (cmd.kind == KIND_CHECK) begin
						state_d = (count_q == '0) ? ST_DONE : ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				ram_re = 1'b1;
				if (last_idx) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			count_q       <= '0;
			idx_q         <= '0;
			hit_q         <= 1'b0;
			rd_pending_s1 <= 1'b0;
			overflow_q    <= 1'b0;
			del_reads_q   <= '0;
			tot_reads_q   <= '0;
			del_bases_q   <= '0;
			tot_bases_q   <= '0;
			res_valid_q   <= 1'b0;
		end else begin
			state_q       <= state_d;
			rd_pending_s1 <= (state_q == ST_SCAN);
			if (rd_pending_s1 && match) begin
				hit_q <= 1'b1;
			end
			if (pop && res_valid_q && (state_q != ST_DONE)) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					hit_q <= 1'b0;
					if (cmd_valid) begin
						unique case (cmd.kind)
							KIND_LOAD: begin
								if (count_q < FULL_COUNT) begin
									count_q <= count_q + CW'(1);
								end else begin
									overflow_q <= 1'b1;
								end
							end
							KIND_CLEAR: begin
								count_q     <= '0;
								overflow_q  <= 1'b0;
								del_reads_q <= '0;
								tot_reads_q <= '0;
								del_bases_q <= '0;
								tot_bases_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_SCAN: begin
					idx_q <= idx_q + AW'(1);
				end
				ST_DRAIN: begin
				end
				ST_DONE: begin
					if (slot_free) begin
						res_valid_q <= 1'b1;
						tot_reads_q <= tot_reads_n;
						tot_bases_q <= tot_bases_n;
						if (hit_q) begin
							del_reads_q <= del_reads_n;
							del_bases_q <= del_bases_n;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && cmd_valid) begin
			cmd_q <= cmd;
		end
		if (state_q == ST_DONE && slot_free) begin
			res_q.keep           <= !hit_q;
			res_q.total_reads    <= tot_reads_n;
			res_q.total_bases    <= tot_bases_n;
			res_q.deleted_reads  <= hit_q ? del_reads_n : del_reads_q;
			res_q.deleted_bases  <= hit_q ? del_bases_n : del_bases_q;
			res_q.table_overflow <= overflow_q;
		end
	end

	assign empty = !res_valid_q;
	assign res   = res_q;

endmodule
